FILE: sv/rnis_pkg.sv
package rnis_pkg;

  localparam int unsigned TimeBytes = 7;
  localparam int unsigned TimeWidth = 8 * TimeBytes;

  localparam logic [7:0] TimeBaseReg = 8'h00;
  localparam logic [7:0] SecondsMask = 8'h7F;
  localparam logic [7:0] HourMask    = 8'h3F;
  localparam int unsigned HourFmtBit = 6;
  localparam int unsigned HourByte   = 2;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_TIME_READ = 3'd1,
    MODE_TIME_WRITE = 3'd2,
    MODE_RAM_READ  = 3'd3,
    MODE_RAM_WRITE = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START_WR  = 3'd1,
    CMD_START_RD  = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5,
    CMD_STOP      = 3'd6
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_RTC_ADDR = 1'b0,
    CFG_RAM_ADDR = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    RTC_IDLE     = 4'd0,
    RTC_WAIT     = 4'd1,
    RTC_START_WR = 4'd2,
    RTC_REG_ADDR = 4'd3,
    RTC_START_RD = 4'd4,
    RTC_BYTE0    = 4'd5,
    RTC_BYTE1    = 4'd6,
    RTC_BYTE2    = 4'd7,
    RTC_BYTE3    = 4'd8,
    RTC_BYTE4    = 4'd9,
    RTC_BYTE5    = 4'd10,
    RTC_BYTE6    = 4'd11,
    RTC_STOP     = 4'd12
  } rtc_step_e;

  typedef enum logic [2:0] {
    RAM_IDLE     = 3'd0,
    RAM_WAIT     = 3'd1,
    RAM_START_WR = 3'd2,
    RAM_ADDR     = 3'd3,
    RAM_START_RD = 3'd4,
    RAM_DATA     = 3'd5,
    RAM_STOP     = 3'd6
  } ram_step_e;

  typedef struct packed {
    cmd_e       code;
    logic [7:0] data;
  } cmd_t;

endpackage

FILE: sv/rnis_in_if.sv
interface rnis_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     mode;
  logic                           master_busy;
  logic [7:0]                     master_rx_byte;
  logic [rnis_pkg::TimeWidth-1:0] time_in;
  logic [7:0]                     ram_address;
  logic [7:0]                     ram_data_in;

  modport source (
    output valid, mode, master_busy, master_rx_byte, time_in, ram_address, ram_data_in,
    input  ready
  );
  modport sink (
    input  valid, mode, master_busy, master_rx_byte, time_in, ram_address, ram_data_in,
    output ready
  );
endinterface

FILE: sv/rnis_out_if.sv
interface rnis_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     bus_command;
  logic [7:0]                     bus_byte;
  logic                           rtc_active;
  logic                           ram_active;
  logic [rnis_pkg::TimeWidth-1:0] time_out;
  logic [7:0]                     ram_data_out;

  modport source (
    output valid, bus_command, bus_byte, rtc_active, ram_active, time_out, ram_data_out,
    input  ready
  );
  modport sink (
    input  valid, bus_command, bus_byte, rtc_active, ram_active, time_out, ram_data_out,
    output ready
  );
endinterface

FILE: sv/rnis_rtc_seq.sv
module rnis_rtc_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           load_write_i,
  input  logic [rnis_pkg::TimeWidth-1:0] load_time_i,
  input  logic                           tick_i,
  input  logic                           busy_i,
  input  logic [7:0]                     rx_i,
  input  rnis_pkg::ram_step_e            ram_step_i,
  input  logic [6:0]                     dev_addr_i,
  output rnis_pkg::rtc_step_e            step_o,
  output rnis_pkg::cmd_t                 cmd_o,
  output logic                           active_o,
  output logic [rnis_pkg::TimeWidth-1:0] time_o
);

  rnis_pkg::rtc_step_e step_q, step_d;
  logic                wr_q, wr_d;
  logic [7:0]          regs_q [rnis_pkg::TimeBytes];
  logic [7:0]          regs_d [rnis_pkg::TimeBytes];
  logic [2:0]          wr_idx;
  logic [2:0]          rd_idx;

  assign wr_idx = 3'(4'(step_q) - 4'(rnis_pkg::RTC_BYTE0));
  assign rd_idx = 3'(4'(step_q) - 4'(rnis_pkg::RTC_BYTE0) - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rnis_pkg::RTC_IDLE;
      wr_q   <= 1'b0;
      for (int i = 0; i < rnis_pkg::TimeBytes; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      step_q <= step_d;
      wr_q   <= wr_d;
      regs_q <= regs_d;
    end
  end

  always_comb begin
    step_d = step_q;
    wr_d   = wr_q;
    regs_d = regs_q;
    cmd_o  = '{code: rnis_pkg::CMD_NONE, data: 8'h00};
    if (load_i) begin
      wr_d = load_write_i;
      if (load_write_i) begin
        for (int i = 0; i < rnis_pkg::TimeBytes; i++) begin
          regs_d[i] = load_time_i[8*i +: 8];
        end
      end
      step_d = rnis_pkg::RTC_WAIT;
    end else if (tick_i) begin
      unique case (step_q)
        rnis_pkg::RTC_IDLE: begin
        end
        rnis_pkg::RTC_WAIT: begin
          if (ram_step_i == rnis_pkg::RAM_IDLE || ram_step_i == rnis_pkg::RAM_WAIT) begin
            step_d = rnis_pkg::RTC_START_WR;
          end
        end
        rnis_pkg::RTC_START_WR: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_START_WR, data: {1'b0, dev_addr_i}};
            step_d = rnis_pkg::RTC_REG_ADDR;
          end
        end
        rnis_pkg::RTC_REG_ADDR: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_WRITE, data: rnis_pkg::TimeBaseReg};
            step_d = wr_q ? rnis_pkg::RTC_BYTE0 : rnis_pkg::RTC_START_RD;
          end
        end
        rnis_pkg::RTC_START_RD: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_START_RD, data: {1'b0, dev_addr_i}};
            step_d = rnis_pkg::RTC_BYTE0;
          end
        end
        rnis_pkg::RTC_BYTE0, rnis_pkg::RTC_BYTE1, rnis_pkg::RTC_BYTE2,
        rnis_pkg::RTC_BYTE3, rnis_pkg::RTC_BYTE4, rnis_pkg::RTC_BYTE5,
        rnis_pkg::RTC_BYTE6: begin
          if (!busy_i) begin
            if (wr_q) begin
              cmd_o = '{code: rnis_pkg::CMD_WRITE, data: regs_q[wr_idx]};
            end else begin
              if (step_q != rnis_pkg::RTC_BYTE0) begin
                regs_d[rd_idx] = rx_i;
              end
              cmd_o = '{code: (step_q == rnis_pkg::RTC_BYTE6) ? rnis_pkg::CMD_READ_NACK
                                                              : rnis_pkg::CMD_READ_ACK,
                        data: 8'h00};
            end
            step_d = rnis_pkg::rtc_step_e'(4'(step_q) + 4'd1);
          end
        end
        rnis_pkg::RTC_STOP: begin
          if (!busy_i) begin
            if (!wr_q) begin
              regs_d[rnis_pkg::TimeBytes-1] = rx_i;
            end
            cmd_o  = '{code: rnis_pkg::CMD_STOP, data: 8'h00};
            step_d = rnis_pkg::RTC_IDLE;
          end
        end
        default: begin
          step_d = rnis_pkg::RTC_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < rnis_pkg::TimeBytes; i++) begin
      time_o[8*i +: 8] = regs_d[i];
    end
    time_o[7:0] = regs_d[0] & rnis_pkg::SecondsMask;
    if (regs_d[rnis_pkg::HourByte][rnis_pkg::HourFmtBit]) begin
      time_o[8*rnis_pkg::HourByte +: 8] = regs_d[rnis_pkg::HourByte] & rnis_pkg::HourMask;
    end
  end

  assign step_o   = step_d;
  assign active_o = (step_d != rnis_pkg::RTC_IDLE) && (step_d != rnis_pkg::RTC_WAIT);

endmodule

FILE: sv/rnis_ram_seq.sv
module rnis_ram_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                load_write_i,
  input  logic [7:0]          load_addr_i,
  input  logic [7:0]          load_data_i,
  input  logic                tick_i,
  input  logic                busy_i,
  input  logic [7:0]          rx_i,
  input  rnis_pkg::rtc_step_e rtc_step_i,
  input  logic [6:0]          dev_addr_i,
  output rnis_pkg::ram_step_e step_o,
  output rnis_pkg::cmd_t      cmd_o,
  output logic                active_o,
  output logic [7:0]          data_o
);

  rnis_pkg::ram_step_e step_q, step_d;
  logic                wr_q, wr_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          data_q, data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rnis_pkg::RAM_IDLE;
      wr_q   <= 1'b0;
      addr_q <= '0;
      data_q <= '0;
    end else begin
      step_q <= step_d;
      wr_q   <= wr_d;
      addr_q <= addr_d;
      data_q <= data_d;
    end
  end

  always_comb begin
    step_d = step_q;
    wr_d   = wr_q;
    addr_d = addr_q;
    data_d = data_q;
    cmd_o  = '{code: rnis_pkg::CMD_NONE, data: 8'h00};
    if (load_i) begin
      wr_d   = load_write_i;
      addr_d = load_addr_i;
      if (load_write_i) begin
        data_d = load_data_i;
      end
      step_d = rnis_pkg::RAM_WAIT;
    end else if (tick_i) begin
      unique case (step_q)
        rnis_pkg::RAM_IDLE: begin
        end
        rnis_pkg::RAM_WAIT: begin
          if (rtc_step_i == rnis_pkg::RTC_IDLE || rtc_step_i == rnis_pkg::RTC_WAIT) begin
            step_d = rnis_pkg::RAM_START_WR;
          end
        end
        rnis_pkg::RAM_START_WR: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_START_WR, data: {1'b0, dev_addr_i}};
            step_d = rnis_pkg::RAM_ADDR;
          end
        end
        rnis_pkg::RAM_ADDR: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_WRITE, data: addr_q};
            step_d = wr_q ? rnis_pkg::RAM_DATA : rnis_pkg::RAM_START_RD;
          end
        end
        rnis_pkg::RAM_START_RD: begin
          if (!busy_i) begin
            cmd_o  = '{code: rnis_pkg::CMD_START_RD, data: {1'b0, dev_addr_i}};
            step_d = rnis_pkg::RAM_DATA;
          end
        end
        rnis_pkg::RAM_DATA: begin
          if (!busy_i) begin
            if (wr_q) begin
              cmd_o = '{code: rnis_pkg::CMD_WRITE, data: data_q};
            end else begin
              cmd_o = '{code: rnis_pkg::CMD_READ_NACK, data: 8'h00};
            end
            step_d = rnis_pkg::RAM_STOP;
          end
        end
        rnis_pkg::RAM_STOP: begin
          if (!busy_i) begin
            if (!wr_q) begin
              data_d = rx_i;
            end
            cmd_o  = '{code: rnis_pkg::CMD_STOP, data: 8'h00};
            step_d = rnis_pkg::RAM_IDLE;
          end
        end
        default: begin
          step_d = rnis_pkg::RAM_IDLE;
        end
      endcase
    end
  end

  assign step_o   = step_d;
  assign active_o = (step_d != rnis_pkg::RAM_IDLE) && (step_d != rnis_pkg::RAM_WAIT);
  assign data_o   = data_d;

endmodule

FILE: sv/rtc_nvram_i2c_sequencer.sv
// Channel   Dir  Handshake      Payload
// item_i    in   valid/ready    mode, master_busy, master_rx_byte, time_in, ram_address,
//                               ram_data_in
// result_o  out  valid/ready    bus_command, bus_byte, rtc_active, ram_active, time_out,
//                               ram_data_out
// cfg       in   cfg_we_i       cfg_idx_i selects the register, cfg_data_i is written
//
// An item passes from the input register to the result register, where its result waits
// to be taken; one item is taken every cycle while the result register does not stall.
// The sequencer states update as the item moves from the input to the result register.
// A stalled result register holds the input register, which then drops item_i.ready.
// Reset clears both sequencers, the time bytes and the RAM data byte.
module rtc_nvram_i2c_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  rnis_in_if.sink    item_i,
  rnis_out_if.source result_o
);

  logic [6:0] rtc_addr_q;
  logic [6:0] ram_addr_q;

  logic                           in_valid_q;
  logic [2:0]                     mode_q;
  logic                           busy_q;
  logic [7:0]                     rx_q;
  logic [rnis_pkg::TimeWidth-1:0] time_in_q;
  logic [7:0]                     ram_address_q;
  logic [7:0]                     ram_data_in_q;

  logic                           out_valid_q;
  rnis_pkg::cmd_t                 cmd_q;
  logic                           rtc_active_q;
  logic                           ram_active_q;
  logic [rnis_pkg::TimeWidth-1:0] time_out_q;
  logic [7:0]                     ram_data_out_q;

  logic out_free;
  logic proc;
  logic is_rtc_start;
  logic is_ram_start;
  logic tick;

  rnis_pkg::rtc_step_e            rtc_step;
  rnis_pkg::ram_step_e            ram_step;
  rnis_pkg::ram_step_e            ram_step_q;
  rnis_pkg::cmd_t                 rtc_cmd;
  rnis_pkg::cmd_t                 ram_cmd;
  rnis_pkg::cmd_t                 cmd;
  logic                           rtc_active;
  logic                           ram_active;
  logic [rnis_pkg::TimeWidth-1:0] time_out;
  logic [7:0]                     ram_data_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtc_addr_q <= 7'd104;
      ram_addr_q <= 7'd104;
    end else if (cfg_we_i) begin
      unique case (rnis_pkg::cfg_idx_e'(cfg_idx_i))
        rnis_pkg::CFG_RTC_ADDR: rtc_addr_q <= cfg_data_i;
        rnis_pkg::CFG_RAM_ADDR: ram_addr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free     = !out_valid_q || result_o.ready;
  assign proc         = in_valid_q && out_free;
  assign item_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      mode_q        <= item_i.mode;
      busy_q        <= item_i.master_busy;
      rx_q          <= item_i.master_rx_byte;
      time_in_q     <= item_i.time_in;
      ram_address_q <= item_i.ram_address;
      ram_data_in_q <= item_i.ram_data_in;
    end
  end

  assign is_rtc_start = (mode_q == rnis_pkg::MODE_TIME_READ)
                     || (mode_q == rnis_pkg::MODE_TIME_WRITE);
  assign is_ram_start = (mode_q == rnis_pkg::MODE_RAM_READ)
                     || (mode_q == rnis_pkg::MODE_RAM_WRITE);
  assign tick         = proc && !is_rtc_start && !is_ram_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_step_q <= rnis_pkg::RAM_IDLE;
    end else begin
      ram_step_q <= ram_step;
    end
  end

  rnis_rtc_seq u_rtc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (proc && is_rtc_start),
    .load_write_i (mode_q == rnis_pkg::MODE_TIME_WRITE),
    .load_time_i  (time_in_q),
    .tick_i       (tick),
    .busy_i       (busy_q),
    .rx_i         (rx_q),
    .ram_step_i   (ram_step_q),
    .dev_addr_i   (rtc_addr_q),
    .step_o       (rtc_step),
    .cmd_o        (rtc_cmd),
    .active_o     (rtc_active),
    .time_o       (time_out)
  );

  rnis_ram_seq u_ram (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (proc && is_ram_start),
    .load_write_i (mode_q == rnis_pkg::MODE_RAM_WRITE),
    .load_addr_i  (ram_address_q),
    .load_data_i  (ram_data_in_q),
    .tick_i       (tick),
    .busy_i       (busy_q),
    .rx_i         (rx_q),
    .rtc_step_i   (rtc_step),
    .dev_addr_i   (ram_addr_q),
    .step_o       (ram_step),
    .cmd_o        (ram_cmd),
    .active_o     (ram_active),
    .data_o       (ram_data_out)
  );

  assign cmd = (ram_cmd.code != rnis_pkg::CMD_NONE) ? ram_cmd : rtc_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      cmd_q          <= cmd;
      rtc_active_q   <= rtc_active;
      ram_active_q   <= ram_active;
      time_out_q     <= time_out;
      ram_data_out_q <= ram_data_out;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.bus_command  = cmd_q.code;
  assign result_o.bus_byte     = cmd_q.data;
  assign result_o.rtc_active   = rtc_active_q;
  assign result_o.ram_active   = ram_active_q;
  assign result_o.time_out     = time_out_q;
  assign result_o.ram_data_out = ram_data_out_q;

  a_one_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rtc_active_q && ram_active_q))
    else $error("both sequencers own the bus");

  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (is_rtc_start || is_ram_start)) |=> (cmd_q.code == rnis_pkg::CMD_NONE))
    else $error("start transfer issued a bus command");

  a_busy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && busy_q) |=> (cmd_q.code == rnis_pkg::CMD_NONE))
    else $error("bus command issued while the master is busy");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cmd_q.code == rnis_pkg::CMD_NONE) |-> (cmd_q.data == 8'h00))
    else $error("idle command carries a byte");

endmodule
